/* rtl/core/tcm_pkg.sv */
// Shared constants, codes and types of the touch calibration and mapping block.
`timescale 1ns / 1ps

package tcm_pkg;

	// Raw sample and fixed point formats.
	localparam int ADC_BITS  = 12;
	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W     = 12;

	// The divider takes 3*smax << FRAC_BITS over 5*|delta|, or smax << FRAC_BITS over five.
	localparam int NUM_W  = CFG_W + 2 + FRAC_BITS;
	localparam int DEN_W  = ADC_BITS + 3;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	// Scale is Q16.F, offset is Q24.F, products and sums carry headroom.
	localparam int SCALE_W = 16 + FRAC_BITS;
	localparam int OFF_W   = 24 + FRAC_BITS;
	localparam int PROD_W  = ADC_BITS + 1 + SCALE_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int PIX_W   = SUM_W - 1 - FRAC_BITS;

	// The calibration points sit at one fifth and four fifths of the screen.
	localparam logic [DEN_W-1:0] FIFTH_DEN = DEN_W'(5);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SMAX_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMAX_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [CFG_W-1:0] RST_SMAX_X    = 12'd239;
	localparam logic [CFG_W-1:0] RST_SMAX_Y    = 12'd319;
	localparam logic [CFG_W-1:0] RST_THRESHOLD = 12'd400;

	// Event kinds of a result.
	localparam logic [1:0] EV_MAP   = 2'd0;
	localparam logic [1:0] EV_POINT = 2'd1;
	localparam logic [1:0] EV_DONE  = 2'd2;
	localparam logic [1:0] EV_FAIL  = 2'd3;

	// Touch phases.
	localparam logic [1:0] PH_WAIT    = 2'd0;
	localparam logic [1:0] PH_CAPTURE = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/tcm_div.sv */
// Bit-serial restoring divider shared by the scale and offset computations.
`timescale 1ns / 1ps

module tcm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tcm_pkg::div_req_t req,
	output tcm_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [tcm_pkg::DCNT_W-1:0]    cnt_q;
	logic [tcm_pkg::DEN_W-1:0]     rem_q;
	logic [tcm_pkg::DEN_W-1:0]     den_q;
	logic [tcm_pkg::NUM_W-1:0]     quo_q;
	logic [tcm_pkg::DEN_W:0]       trial;
	logic [tcm_pkg::DEN_W:0]       diff;
	logic                          take;

	// One quotient bit per cycle: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, quo_q[tcm_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tcm_pkg::DCNT_W'(tcm_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tcm_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[tcm_pkg::DEN_W-1:0] : trial[tcm_pkg::DEN_W-1:0];
			quo_q <= {quo_q[tcm_pkg::NUM_W-2:0], take};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with an empty count");

endmodule

/* rtl/core/touch_calibrate_and_map.sv */
// Top level of the touch panel calibration and coordinate mapping block.
`timescale 1ns / 1ps

// The input channel carries one request per raw sample (cmd low) or a start of
// calibration (cmd high). A request is taken at a clock edge with in_valid high
// and in_stall low. Results leave on the output channel under out_valid and
// out_stall; at most one result follows from any request.
// A sample that completes no touch leaves the block ready for the next request.
// A completed touch when calibrated passes through the capture, a completion
// step, a multiply and an add for each axis on the shared multiplier, and the
// load of the output register. A calibration point passes through the capture,
// the completion step and the load. The third point runs four divisions on the
// bit-serial divider and a multiply and a saturating add per axis for the
// offsets, or none when the points coincide on an axis. The input is stalled
// for the whole of that work. The output register holds its result while
// out_stall is high. In the meantime the block keeps taking requests that give no
// result; it stalls the input while the sequencer works or a new result waits.
// Reset restores the screen size and press threshold defaults, clears the
// calibration, and leaves the output channel empty.
module touch_calibrate_and_map (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcm_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [tcm_pkg::ADC_BITS-1:0]   raw_x,
	input  logic [tcm_pkg::ADC_BITS-1:0]   raw_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     event_kind,
	output logic [1:0]                     point_index,
	output logic [tcm_pkg::OUT_W-1:0]      out_x,
	output logic [tcm_pkg::OUT_W-1:0]      out_y
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_CPL      = 4'd1;
	localparam logic [3:0] ST_SCL_GO   = 4'd2;
	localparam logic [3:0] ST_SCL_WAIT = 4'd3;
	localparam logic [3:0] ST_BAS_GO   = 4'd4;
	localparam logic [3:0] ST_BAS_WAIT = 4'd5;
	localparam logic [3:0] ST_OFF_MUL  = 4'd6;
	localparam logic [3:0] ST_OFF_ADD  = 4'd7;
	localparam logic [3:0] ST_MAP_MUL  = 4'd8;
	localparam logic [3:0] ST_MAP_ADD  = 4'd9;
	localparam logic [3:0] ST_EMIT     = 4'd10;

	localparam logic signed [tcm_pkg::OFF_W-1:0] OFF_MAX = {1'b0, {(tcm_pkg::OFF_W-1){1'b1}}};
	localparam logic signed [tcm_pkg::OFF_W-1:0] OFF_MIN = {1'b1, {(tcm_pkg::OFF_W-1){1'b0}}};

	// Configuration registers.
	logic [tcm_pkg::CFG_W-1:0] smax_x_q, smax_y_q, thr_q;

	// Touch and calibration state.
	logic [3:0]                        state_q;
	logic [1:0]                        phase_q;
	logic                              calibrating_q, calibrated_q;
	logic [1:0]                        cal_count_q;
	logic [tcm_pkg::ADC_BITS-1:0]      held_x_q, held_y_q;
	logic [tcm_pkg::ADC_BITS-1:0]      first_x_q, first_y_q, second_x_q, third_y_q;
	logic signed [tcm_pkg::SCALE_W-1:0] scale_x_q, scale_y_q;
	logic signed [tcm_pkg::OFF_W-1:0]  offset_x_q, offset_y_q;

	// Working registers of the sequencer.
	logic                              axis_q;
	logic [tcm_pkg::NUM_W-1:0]         base_q;
	logic signed [tcm_pkg::PROD_W-1:0] prod_q;
	logic [tcm_pkg::OUT_W-1:0]         px_q;
	logic                              okx_q;

	// Result waiting for the output register, and the output register itself.
	logic [1:0]                res_kind_q, res_idx_q;
	logic [tcm_pkg::OUT_W-1:0] res_x_q, res_y_q;
	logic                      out_valid_q;
	logic [1:0]                out_kind_q, out_idx_q;
	logic [tcm_pkg::OUT_W-1:0] out_x_q, out_y_q;

	tcm_pkg::div_req_t dreq;
	tcm_pkg::div_rsp_t drsp;

	logic                              down;
	logic                              emit_load;
	logic [tcm_pkg::CFG_W-1:0]         smax_sel;
	logic [tcm_pkg::ADC_BITS-1:0]      p_lo, p_hi;
	logic [tcm_pkg::ADC_BITS:0]        delta;
	logic                              delta_neg;
	logic [tcm_pkg::ADC_BITS-1:0]      delta_mag;
	logic [tcm_pkg::NUM_W-1:0]         num_scale, num_base;
	logic signed [tcm_pkg::SCALE_W-1:0] quo_ext, scale_new;
	logic [tcm_pkg::ADC_BITS-1:0]      mul_a;
	logic signed [tcm_pkg::SCALE_W-1:0] mul_b;
	logic signed [tcm_pkg::PROD_W-1:0] mul_prod;
	logic signed [tcm_pkg::SUM_W-1:0]  base_ext, prod_ext, off_sel_ext;
	logic signed [tcm_pkg::SUM_W-1:0]  off_sum, map_sum;
	logic [tcm_pkg::SUM_W-tcm_pkg::OFF_W:0] off_hi;
	logic signed [tcm_pkg::OFF_W-1:0]  off_sat;
	logic [tcm_pkg::PIX_W-1:0]         map_pix;
	logic                              map_ok, map_ok_both;
	logic [tcm_pkg::OUT_W-1:0]         map_px;

	// A request is taken only while the sequencer is idle.
	assign in_stall = (state_q != ST_IDLE);
	assign down     = (raw_x > thr_q) && (raw_y > thr_q);

	// Operand selection for the axis being worked on.
	assign smax_sel  = axis_q ? smax_y_q : smax_x_q;
	assign p_lo      = axis_q ? first_y_q : first_x_q;
	assign p_hi      = axis_q ? third_y_q : second_x_q;
	assign delta     = {1'b0, p_hi} - {1'b0, p_lo};
	assign delta_neg = delta[tcm_pkg::ADC_BITS];
	assign delta_mag = delta_neg ? tcm_pkg::ADC_BITS'(-delta) : delta[tcm_pkg::ADC_BITS-1:0];

	// Scale divides 3*smax << F by 5*|delta|; the offset base divides smax << F by five.
	assign num_scale = (tcm_pkg::NUM_W'({smax_sel, 1'b0}) + tcm_pkg::NUM_W'(smax_sel))
		<< tcm_pkg::FRAC_BITS;
	assign num_base  = tcm_pkg::NUM_W'(smax_sel) << tcm_pkg::FRAC_BITS;

	always_comb begin
		dreq.start    = (state_q == ST_SCL_GO) || (state_q == ST_BAS_GO);
		dreq.dividend = (state_q == ST_BAS_GO) ? num_base : num_scale;
		dreq.divisor  = (state_q == ST_BAS_GO) ? tcm_pkg::FIFTH_DEN :
			(tcm_pkg::DEN_W'(delta_mag) << 2) + tcm_pkg::DEN_W'(delta_mag);
	end

	tcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign quo_ext   = $signed(tcm_pkg::SCALE_W'(drsp.quotient));
	assign scale_new = delta_neg ? -quo_ext : quo_ext;

	// The shared multiplier: a raw coordinate times the scale of the current axis.
	always_comb begin
		if (state_q == ST_MAP_MUL) begin
			mul_a = axis_q ? held_y_q : held_x_q;
		end else begin
			mul_a = p_lo;
		end
	end
	assign mul_b    = axis_q ? scale_y_q : scale_x_q;
	assign mul_prod = $signed({1'b0, mul_a}) * mul_b;

	// Offset: base minus first point times scale, saturated to the offset format.
	assign base_ext    = $signed({{(tcm_pkg::SUM_W-tcm_pkg::NUM_W){1'b0}}, base_q});
	assign prod_ext    = tcm_pkg::SUM_W'(prod_q);
	assign off_sel_ext = axis_q ? tcm_pkg::SUM_W'(offset_y_q) : tcm_pkg::SUM_W'(offset_x_q);
	assign off_sum     = base_ext - prod_ext;
	assign off_hi      = off_sum[tcm_pkg::SUM_W-1:tcm_pkg::OFF_W-1];

	always_comb begin
		if ((&off_hi) || !(|off_hi)) begin
			off_sat = off_sum[tcm_pkg::OFF_W-1:0];
		end else if (off_sum[tcm_pkg::SUM_W-1]) begin
			off_sat = OFF_MIN;
		end else begin
			off_sat = OFF_MAX;
		end
	end

	// Mapping: a negative value or a pixel past the screen edge sends the touch to (0,0).
	assign map_sum     = prod_ext + off_sel_ext;
	assign map_pix     = map_sum[tcm_pkg::SUM_W-2:tcm_pkg::FRAC_BITS];
	assign map_ok      = !map_sum[tcm_pkg::SUM_W-1] &&
		(map_pix <= tcm_pkg::PIX_W'(smax_sel));
	assign map_px      = map_sum[tcm_pkg::FRAC_BITS +: tcm_pkg::OUT_W];
	assign map_ok_both = okx_q && map_ok;

	// Configuration writes; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smax_x_q <= tcm_pkg::RST_SMAX_X;
			smax_y_q <= tcm_pkg::RST_SMAX_Y;
			thr_q    <= tcm_pkg::RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				tcm_pkg::REG_SMAX_X:    smax_x_q <= cfg_wdata;
				tcm_pkg::REG_SMAX_Y:    smax_y_q <= cfg_wdata;
				tcm_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The staged result moves into the output register once that register is free.
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= tcm_pkg::PH_WAIT;
			calibrating_q <= 1'b0;
			calibrated_q  <= 1'b0;
			cal_count_q   <= '0;
			held_x_q      <= '0;
			held_y_q      <= '0;
			first_x_q     <= '0;
			first_y_q     <= '0;
			second_x_q    <= '0;
			third_y_q     <= '0;
			scale_x_q     <= '0;
			scale_y_q     <= '0;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			axis_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd) begin
							// Start of calibration; the old calibration stays until the end.
							calibrating_q <= 1'b1;
							cal_count_q   <= '0;
							phase_q       <= tcm_pkg::PH_WAIT;
						end else if (!calibrating_q && !calibrated_q) begin
							phase_q <= tcm_pkg::PH_WAIT;
						end else begin
							case (phase_q)
								tcm_pkg::PH_CAPTURE: begin
									held_x_q <= raw_x;
									held_y_q <= raw_y;
									if (down) begin
										phase_q <= tcm_pkg::PH_RELEASE;
									end else begin
										phase_q <= tcm_pkg::PH_WAIT;
										state_q <= ST_CPL;
									end
								end
								tcm_pkg::PH_RELEASE: begin
									if (!down) begin
										phase_q <= tcm_pkg::PH_WAIT;
										state_q <= ST_CPL;
									end
								end
								default: begin
									phase_q <= down ? tcm_pkg::PH_CAPTURE : tcm_pkg::PH_WAIT;
								end
							endcase
						end
					end
				end
				ST_CPL: begin
					axis_q <= 1'b0;
					if (calibrating_q) begin
						case (cal_count_q)
							2'd0: begin
								first_x_q   <= held_x_q;
								first_y_q   <= held_y_q;
								cal_count_q <= 2'd1;
								state_q     <= ST_EMIT;
							end
							2'd1: begin
								second_x_q  <= held_x_q;
								cal_count_q <= 2'd2;
								state_q     <= ST_EMIT;
							end
							default: begin
								third_y_q     <= held_y_q;
								calibrating_q <= 1'b0;
								cal_count_q   <= '0;
								if ((second_x_q == first_x_q) || (held_y_q == first_y_q)) begin
									calibrated_q <= 1'b0;
									state_q      <= ST_EMIT;
								end else begin
									state_q <= ST_SCL_GO;
								end
							end
						endcase
					end else begin
						state_q <= ST_MAP_MUL;
					end
				end
				ST_SCL_GO: state_q <= ST_SCL_WAIT;
				ST_SCL_WAIT: begin
					if (drsp.done) begin
						if (axis_q) begin
							scale_y_q <= scale_new;
						end else begin
							scale_x_q <= scale_new;
						end
						state_q <= ST_BAS_GO;
					end
				end
				ST_BAS_GO: state_q <= ST_BAS_WAIT;
				ST_BAS_WAIT: begin
					if (drsp.done) begin
						state_q <= ST_OFF_MUL;
					end
				end
				ST_OFF_MUL: state_q <= ST_OFF_ADD;
				ST_OFF_ADD: begin
					if (axis_q) begin
						offset_y_q   <= off_sat;
						calibrated_q <= 1'b1;
						state_q      <= ST_EMIT;
					end else begin
						offset_x_q <= off_sat;
						axis_q     <= 1'b1;
						state_q    <= ST_SCL_GO;
					end
				end
				ST_MAP_MUL: state_q <= ST_MAP_ADD;
				ST_MAP_ADD: begin
					if (axis_q) begin
						state_q <= ST_EMIT;
					end else begin
						axis_q  <= 1'b1;
						state_q <= ST_MAP_MUL;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers and the staged result; their values matter only once set.
	always_ff @(posedge clk) begin
		if (state_q == ST_BAS_WAIT && drsp.done) begin
			base_q <= drsp.quotient;
		end
		if (state_q == ST_OFF_MUL || state_q == ST_MAP_MUL) begin
			prod_q <= mul_prod;
		end
		if (state_q == ST_MAP_ADD && !axis_q) begin
			px_q  <= map_px;
			okx_q <= map_ok;
		end
		if (state_q == ST_CPL) begin
			res_x_q <= tcm_pkg::OUT_W'(held_x_q);
			res_y_q <= tcm_pkg::OUT_W'(held_y_q);
			res_idx_q <= cal_count_q;
			if (!calibrating_q) begin
				res_kind_q <= tcm_pkg::EV_MAP;
				res_idx_q  <= '0;
			end else if (cal_count_q == 2'd0 || cal_count_q == 2'd1) begin
				res_kind_q <= tcm_pkg::EV_POINT;
			end else begin
				res_idx_q <= 2'd2;
				if ((second_x_q == first_x_q) || (held_y_q == first_y_q)) begin
					res_kind_q <= tcm_pkg::EV_FAIL;
				end else begin
					res_kind_q <= tcm_pkg::EV_DONE;
				end
			end
		end
		if (state_q == ST_MAP_ADD && axis_q) begin
			res_x_q <= map_ok_both ? px_q : '0;
			res_y_q <= map_ok_both ? map_px : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_kind_q <= res_kind_q;
			out_idx_q  <= res_idx_q;
			out_x_q    <= res_x_q;
			out_y_q    <= res_y_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = out_kind_q;
	assign point_index = out_idx_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result appeared without passing the emit step");

	a_phase_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (phase_q == tcm_pkg::PH_WAIT))
		else $error("touch phase not at rest while a completed touch is processed");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_SCL_WAIT || state_q == ST_BAS_WAIT))
		else $error("divider finished outside a wait step");

	a_cal_math_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OFF_ADD) |-> !calibrating_q)
		else $error("calibration sequence still open during offset computation");

endmodule
